// File: hw/rtl/block_range_sum_point_update_macros.svh
// ----------------------------------------------------------------------------
// block_range_sum_point_update assertion macros
// Short forms for the concurrent checks of the range-sum block.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RANGE_SUM_POINT_UPDATE_MACROS_SVH
`define BLOCK_RANGE_SUM_POINT_UPDATE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BRSPU_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("brspu check failed");

// antecedent implies consequent in the next cycle
`define BRSPU_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("brspu check failed");

`endif

// File: hw/rtl/brspu_pkg.sv
// ----------------------------------------------------------------------------
// brspu_pkg
// Shared constants and types of the block range-sum / point-update engine.
// ----------------------------------------------------------------------------
package brspu_pkg;

   localparam int MAX_ELEMENTS_DEF = 4096;
   localparam int BLOCK_SIZE_DEF   = 64;

   localparam int CMD_W = 2;
   localparam int POS_W = 13;
   localparam int VAL_W = 16;
   localparam int SUM_W = 28;
   localparam int CNT_W = 13;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SET_DIV,
      ST_SET_MOD,
      ST_Q_DIV_S,
      ST_Q_DIV_E,
      ST_Q_HEAD,
      ST_Q_MID,
      ST_Q_TAIL,
      ST_Q_DRAIN,
      ST_RESP
   } state_type;

endpackage

// File: hw/rtl/brspu_ram.sv
// ----------------------------------------------------------------------------
// brspu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brspu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/brspu_divider.sv
// ----------------------------------------------------------------------------
// brspu_divider
// Divide of an element position by the block size through a reciprocal
// multiply; the product is registered, then quotient and remainder with done.
// Gives block index and offset inside the block.
// ----------------------------------------------------------------------------
module brspu_divider #(
   parameter int MAX_ELEMENTS = brspu_pkg::MAX_ELEMENTS_DEF,
   parameter int BLOCK_SIZE   = brspu_pkg::BLOCK_SIZE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [$clog2(MAX_ELEMENTS)-1:0]       dividend,
   output logic                                  done,
   output logic [((MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE > 1 ?
                  $clog2((MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE) : 1)-1:0] quotient,
   output logic [$clog2(BLOCK_SIZE)-1:0]         remainder
);

   localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int QW = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
   localparam int OW = $clog2(BLOCK_SIZE);
   localparam int PW = $clog2(MAX_ELEMENTS);
   localparam int SH = PW + OW;
   localparam int XW = 2 * PW + 1;
   // ceil(2^SH / BLOCK_SIZE) is exact for every PW-bit dividend
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(BLOCK_SIZE) - 64'd1) /
                                   64'(BLOCK_SIZE);

   logic          stg_ff,  stg_in;
   logic          done_ff, done_in;
   logic [PW-1:0] num_ff,  num_in;
   logic [XW-1:0] prod_ff, prod_in;
   logic [QW-1:0] q_ff,    q_in;
   logic [OW-1:0] r_ff,    r_in;
   logic [QW-1:0] quo;
   logic [XW-1:0] back;

   assign quo  = QW'(prod_ff >> SH);
   assign back = XW'(quo) * XW'(BLOCK_SIZE);

   always_comb begin
      stg_in  = start;
      done_in = stg_ff;
      num_in  = num_ff;
      prod_in = prod_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (start) begin
         num_in  = dividend;
         prod_in = XW'(dividend) * XW'(RECIP);
      end
      if (stg_ff) begin
         q_in = quo;
         r_in = OW'(XW'(num_ff) - back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stg_ff  <= stg_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

// File: hw/rtl/block_range_sum_point_update.sv
// ----------------------------------------------------------------------------
// block_range_sum_point_update
// Range sums with point updates over values split into fixed-size blocks,
// elements and block totals each kept in a RAM.
// ----------------------------------------------------------------------------
// channel  ports                          beat taken when
// req      start/busy, req_*              start & !busy
// rsp      rsp_strobe, rsp_*              rsp_strobe (one cycle, no stall)
// csr      csr_wen, csr_wdata             csr_wen
//
// Load: element write and block total read, then total write. Set: divider,
//   old element and block total read, then both written. Query: divider for
//   start and end, head element reads, whole block totals and tail element
//   reads as the range needs, one RAM read a cycle, then drain and response.
//   A bad range goes straight to the response. After reset and after each
//   csr write a clearing pass zeroes every block total, busy stays high meanwhile.
// Results cannot be stalled; one item is in work at a time.
// ----------------------------------------------------------------------------
`include "block_range_sum_point_update_macros.svh"

module block_range_sum_point_update #(
   parameter int MAX_ELEMENTS = brspu_pkg::MAX_ELEMENTS_DEF,
   parameter int BLOCK_SIZE   = brspu_pkg::BLOCK_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [brspu_pkg::CMD_W-1:0] req_cmd,
   input  logic [brspu_pkg::POS_W-1:0] req_first_pos,
   input  logic [brspu_pkg::POS_W-1:0] req_last_pos,
   input  logic [brspu_pkg::VAL_W-1:0] req_new_value,
   output logic                        rsp_strobe,
   output logic [brspu_pkg::SUM_W-1:0] rsp_range_sum,
   output logic                        rsp_bad_range,
   input  logic                        csr_wen,
   input  logic [brspu_pkg::CNT_W-1:0] csr_wdata
);

   localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int QW    = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
   localparam int PW    = $clog2(MAX_ELEMENTS);
   localparam int CW    = $clog2(MAX_ELEMENTS + 1);
   localparam int OW    = $clog2(BLOCK_SIZE);
   localparam int TOT_W = brspu_pkg::VAL_W + $clog2(BLOCK_SIZE);
   localparam int SUM_W = brspu_pkg::SUM_W;
   localparam int VAL_W = brspu_pkg::VAL_W;
   localparam int CNT_W = brspu_pkg::CNT_W;

   brspu_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff,    count_in;
   logic [CW-1:0]    load_pos_ff, load_pos_in;
   logic [QW-1:0]    load_blk_ff, load_blk_in;
   logic [OW-1:0]    load_off_ff, load_off_in;
   logic [QW-1:0]    clr_ff,      clr_in;
   logic             elem_pend_ff, tot_pend_ff;
   logic [PW-1:0]    s_ff, s_in, e_ff, e_in, cur_ff, cur_in, stop_ff, stop_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [QW-1:0]    bs_ff, bs_in, be_ff, be_in, tadr_ff, tadr_in;
   logic [OW-1:0]    os_ff, os_in, oe_ff, oe_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic             bad_ff, bad_in;

   logic             accept, load_ok, set_ok, query_bad;
   logic [PW-1:0]    first_idx, last_idx;
   logic             elem_issue, tot_issue;

   logic             e_we, e_re, t_we, t_re;
   logic [PW-1:0]    e_waddr, e_raddr;
   logic [VAL_W-1:0] e_wdata, e_rdata;
   logic [QW-1:0]    t_waddr, t_raddr;
   logic [TOT_W-1:0] t_wdata, t_rdata;

   logic             div_start, div_done;
   logic [PW-1:0]    div_dividend;
   logic [QW-1:0]    div_q;
   logic [OW-1:0]    div_r;

   brspu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_en   (e_re),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   brspu_ram #(.WIDTH(TOT_W), .DEPTH(NUM_BLOCKS)) u_total_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   brspu_divider #(.MAX_ELEMENTS(MAX_ELEMENTS), .BLOCK_SIZE(BLOCK_SIZE)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign accept    = start && !busy;
   assign first_idx = PW'(32'(req_first_pos) - 32'd1);
   assign last_idx  = PW'(32'(req_last_pos) - 32'd1);
   assign load_ok   = 32'(load_pos_ff) < 32'(count_ff);
   assign set_ok    = (req_first_pos != '0) &&
                      (32'(req_first_pos) <= 32'(count_ff)) &&
                      (32'(req_first_pos) <= 32'(load_pos_ff));
   assign query_bad = (req_first_pos == '0) || (req_first_pos > req_last_pos) ||
                      (32'(req_last_pos) > 32'(count_ff)) ||
                      (32'(req_last_pos) > 32'(load_pos_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brspu_pkg::ST_CLEAR: begin
            if (clr_ff == QW'(NUM_BLOCKS - 1)) state_in = brspu_pkg::ST_IDLE;
         end
         brspu_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (req_cmd == brspu_pkg::CMD_LOAD) begin
                  if (load_ok) state_in = brspu_pkg::ST_LOAD_RD;
               end else if (req_cmd == brspu_pkg::CMD_SET) begin
                  if (set_ok) state_in = brspu_pkg::ST_SET_DIV;
               end else if (req_cmd == brspu_pkg::CMD_QUERY) begin
                  state_in = query_bad ? brspu_pkg::ST_RESP : brspu_pkg::ST_Q_DIV_S;
               end else begin
                  state_in = brspu_pkg::ST_IDLE;
               end
            end
         end
         brspu_pkg::ST_LOAD_RD: state_in = brspu_pkg::ST_LOAD_WR;
         brspu_pkg::ST_LOAD_WR: state_in = brspu_pkg::ST_IDLE;
         brspu_pkg::ST_SET_DIV: begin
            if (div_done) state_in = brspu_pkg::ST_SET_MOD;
         end
         brspu_pkg::ST_SET_MOD: state_in = brspu_pkg::ST_IDLE;
         brspu_pkg::ST_Q_DIV_S: begin
            if (div_done) state_in = brspu_pkg::ST_Q_DIV_E;
         end
         brspu_pkg::ST_Q_DIV_E: begin
            if (div_done) state_in = brspu_pkg::ST_Q_HEAD;
         end
         brspu_pkg::ST_Q_HEAD: begin
            if (cur_ff == stop_ff) begin
               priority if (bs_ff == be_ff) state_in = brspu_pkg::ST_Q_DRAIN;
               else if ((be_ff - bs_ff) > QW'(1)) state_in = brspu_pkg::ST_Q_MID;
               else state_in = brspu_pkg::ST_Q_TAIL;
            end
         end
         brspu_pkg::ST_Q_MID: begin
            if (tadr_ff == be_ff - QW'(1)) state_in = brspu_pkg::ST_Q_TAIL;
         end
         brspu_pkg::ST_Q_TAIL: begin
            if (cur_ff == stop_ff) state_in = brspu_pkg::ST_Q_DRAIN;
         end
         brspu_pkg::ST_Q_DRAIN: state_in = brspu_pkg::ST_RESP;
         brspu_pkg::ST_RESP:    state_in = brspu_pkg::ST_IDLE;
      endcase
      if (csr_wen) state_in = brspu_pkg::ST_CLEAR;
   end

   // memory, divider and handshake controls
   always_comb begin
      e_we         = 1'b0;
      e_waddr      = s_ff;
      e_wdata      = val_ff;
      e_re         = 1'b0;
      e_raddr      = cur_ff;
      t_we         = 1'b0;
      t_waddr      = bs_ff;
      t_wdata      = '0;
      t_re         = 1'b0;
      t_raddr      = tadr_ff;
      div_start    = 1'b0;
      div_dividend = e_ff;
      elem_issue   = 1'b0;
      tot_issue    = 1'b0;
      busy         = 1'b1;
      rsp_strobe   = 1'b0;
      unique case (state_ff)
         brspu_pkg::ST_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
         end
         brspu_pkg::ST_IDLE: begin
            busy         = 1'b0;
            div_dividend = first_idx;
            div_start    = accept &&
                           (((req_cmd == brspu_pkg::CMD_SET) && set_ok) ||
                            ((req_cmd == brspu_pkg::CMD_QUERY) && !query_bad));
         end
         brspu_pkg::ST_LOAD_RD: begin
            e_we    = 1'b1;
            e_waddr = PW'(load_pos_ff);
            t_re    = 1'b1;
            t_raddr = load_blk_ff;
         end
         brspu_pkg::ST_LOAD_WR: begin
            t_we    = 1'b1;
            t_waddr = load_blk_ff;
            t_wdata = t_rdata + TOT_W'(val_ff);
         end
         brspu_pkg::ST_SET_DIV: begin
            e_re    = div_done;
            e_raddr = s_ff;
            t_re    = div_done;
            t_raddr = div_q;
         end
         brspu_pkg::ST_SET_MOD: begin
            // old value out of the block total, new value in
            e_we    = 1'b1;
            t_we    = 1'b1;
            t_wdata = t_rdata - TOT_W'(e_rdata) + TOT_W'(val_ff);
         end
         brspu_pkg::ST_Q_DIV_S: begin
            div_start = div_done;
         end
         brspu_pkg::ST_Q_DIV_E: begin
         end
         brspu_pkg::ST_Q_HEAD, brspu_pkg::ST_Q_TAIL: begin
            e_re       = 1'b1;
            elem_issue = 1'b1;
         end
         brspu_pkg::ST_Q_MID: begin
            t_re      = 1'b1;
            tot_issue = 1'b1;
         end
         brspu_pkg::ST_Q_DRAIN: begin
         end
         brspu_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
         end
      endcase
   end

   // datapath register next values
   always_comb begin
      count_in    = count_ff;
      load_pos_in = load_pos_ff;
      load_blk_in = load_blk_ff;
      load_off_in = load_off_ff;
      clr_in      = clr_ff;
      s_in        = s_ff;
      e_in        = e_ff;
      val_in      = val_ff;
      bs_in       = bs_ff;
      be_in       = be_ff;
      os_in       = os_ff;
      oe_in       = oe_ff;
      cur_in      = cur_ff;
      stop_in     = stop_ff;
      tadr_in     = tadr_ff;
      acc_in      = acc_ff;
      bad_in      = bad_ff;

      // read data lands in the cycle after the issue
      priority if (elem_pend_ff) acc_in = acc_ff + SUM_W'(e_rdata);
      else if (tot_pend_ff) acc_in = acc_ff + SUM_W'(t_rdata);
      else acc_in = acc_ff;

      unique case (state_ff)
         brspu_pkg::ST_CLEAR: begin
            clr_in = clr_ff + QW'(1);
         end
         brspu_pkg::ST_IDLE: begin
            if (accept) begin
               s_in   = first_idx;
               e_in   = last_idx;
               val_in = req_new_value;
               acc_in = '0;
               bad_in = query_bad;
            end
         end
         brspu_pkg::ST_LOAD_RD: begin
         end
         brspu_pkg::ST_LOAD_WR: begin
            load_pos_in = load_pos_ff + CW'(1);
            if (load_off_ff == OW'(BLOCK_SIZE - 1)) begin
               load_off_in = '0;
               load_blk_in = load_blk_ff + QW'(1);
            end else begin
               load_off_in = load_off_ff + OW'(1);
            end
         end
         brspu_pkg::ST_SET_DIV: begin
            if (div_done) bs_in = div_q;
         end
         brspu_pkg::ST_SET_MOD: begin
         end
         brspu_pkg::ST_Q_DIV_S: begin
            if (div_done) begin
               bs_in = div_q;
               os_in = div_r;
            end
         end
         brspu_pkg::ST_Q_DIV_E: begin
            if (div_done) begin
               be_in  = div_q;
               oe_in  = div_r;
               cur_in = s_ff;
               // head runs to the range end or to the last element of its block
               stop_in = (bs_ff == div_q) ? e_ff
                                          : s_ff - PW'(os_ff) + PW'(BLOCK_SIZE - 1);
            end
         end
         brspu_pkg::ST_Q_HEAD: begin
            cur_in = cur_ff + PW'(1);
            if (cur_ff == stop_ff) begin
               tadr_in = bs_ff + QW'(1);
               cur_in  = e_ff - PW'(oe_ff);
               stop_in = e_ff;
            end
         end
         brspu_pkg::ST_Q_MID: begin
            tadr_in = tadr_ff + QW'(1);
         end
         brspu_pkg::ST_Q_TAIL: begin
            cur_in = cur_ff + PW'(1);
         end
         brspu_pkg::ST_Q_DRAIN: begin
         end
         brspu_pkg::ST_RESP: begin
         end
      endcase

      // new data set: saturate the count, restart loading and clearing
      if (csr_wen) begin
         count_in    = (32'(csr_wdata) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                            : csr_wdata;
         load_pos_in = '0;
         load_blk_in = '0;
         load_off_in = '0;
         clr_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brspu_pkg::ST_CLEAR;
         count_ff     <= '0;
         load_pos_ff  <= '0;
         load_blk_ff  <= '0;
         load_off_ff  <= '0;
         clr_ff       <= '0;
         elem_pend_ff <= 1'b0;
         tot_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         load_pos_ff  <= load_pos_in;
         load_blk_ff  <= load_blk_in;
         load_off_ff  <= load_off_in;
         clr_ff       <= clr_in;
         elem_pend_ff <= elem_issue;
         tot_pend_ff  <= tot_issue;
      end
      s_ff    <= s_in;
      e_ff    <= e_in;
      val_ff  <= val_in;
      bs_ff   <= bs_in;
      be_ff   <= be_in;
      os_ff   <= os_in;
      oe_ff   <= oe_in;
      cur_ff  <= cur_in;
      stop_ff <= stop_in;
      tadr_ff <= tadr_in;
      acc_ff  <= acc_in;
      bad_ff  <= bad_in;
   end

   assign rsp_range_sum = acc_ff;
   assign rsp_bad_range = bad_ff;

   `BRSPU_ASSERT_NOW(a_bad_gives_zero, rsp_strobe && rsp_bad_range, rsp_range_sum == '0)
   `BRSPU_ASSERT_NEXT(a_no_rsp_after_write, accept && (req_cmd != brspu_pkg::CMD_QUERY), !rsp_strobe)
   `BRSPU_ASSERT_NEXT(a_idle_after_rsp, rsp_strobe && !csr_wen, !busy)
   `BRSPU_ASSERT_NOW(a_one_read_landing, elem_pend_ff, !tot_pend_ff)

endmodule

// File: verif/block_range_sum_point_update_tb.sv
// ----------------------------------------------------------------------------
// block_range_sum_point_update_tb
// Drives load, set and range-sum beats through the start/busy port in random
// bursts, rewrites the element count between data sets, and checks every
// strobed sum against a running copy of the stored values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module block_range_sum_point_update_tb;

   localparam int            CMD_W      = brspu_pkg::CMD_W;
   localparam int            POS_W      = brspu_pkg::POS_W;
   localparam int            VAL_W      = brspu_pkg::VAL_W;
   localparam int            SUM_W      = brspu_pkg::SUM_W;
   localparam int            CNT_W      = brspu_pkg::CNT_W;
   localparam int            MAX_ELEMENTS_DEF = brspu_pkg::MAX_ELEMENTS_DEF;
   localparam int            CLK_PERIOD = 20;
   localparam int            BLK        = brspu_pkg::BLOCK_SIZE_DEF;
   localparam int            QUIET      = 300;   // longer than the slowest query
   localparam int            ITEM_GOAL  = 1350;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct {
      logic [SUM_W-1:0] sum;
      logic             bad;
   } answer_type;

   class range_sum_book;
      logic [VAL_W-1:0] values [MAX_ELEMENTS_DEF];
      int unsigned      count_limit;
      int unsigned      loaded;
      int unsigned      errors;
      answer_type       expected_q[$];

      function new();
         count_limit = 0;
         loaded      = 0;
         errors      = 0;
      endfunction

      function void set_element_count(logic [CNT_W-1:0] n);
         count_limit = (n > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : n;
         loaded      = 0;
      endfunction

      function void apply_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] first,
                                  logic [POS_W-1:0] last, logic [VAL_W-1:0] value);
         answer_type       a;
         logic [SUM_W-1:0] acc;
         int unsigned      p;
         case (cmd)
            brspu_pkg::CMD_LOAD: begin
               if (loaded < count_limit) begin
                  values[loaded] = value;
                  loaded++;
               end
            end
            brspu_pkg::CMD_SET: begin
               if (first >= 1 && first <= count_limit && first <= loaded)
                  values[first - 1] = value;
            end
            brspu_pkg::CMD_QUERY: begin
               a.bad = (first < 1) || (first > last) || (last > count_limit) ||
                       (last > loaded);
               acc = '0;
               if (!a.bad) begin
                  for (p = first - 1; p < last; p++)
                     acc += SUM_W'(values[p]);
               end
               a.sum = acc;
               expected_q.push_back(a);
            end
            default: ;
         endcase
      endfunction

      function void check_answer(logic [SUM_W-1:0] sum, logic bad);
         answer_type a;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat: range_sum %0d bad_range %0b", sum, bad);
            errors++;
         end else begin
            a = expected_q.pop_front();
            if (sum !== a.sum) begin
               $error("range_sum mismatch: expected %0d, actual %0d", a.sum, sum);
               errors++;
            end
            if (bad !== a.bad) begin
               $error("bad_range mismatch: expected %0b, actual %0b", a.bad, bad);
               errors++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [CMD_W-1:0] req_cmd = brspu_pkg::CMD_LOAD;
   logic [POS_W-1:0] req_first_pos = '0;
   logic [POS_W-1:0] req_last_pos = '0;
   logic [VAL_W-1:0] req_new_value = '0;
   logic             rsp_strobe;
   logic [SUM_W-1:0] rsp_range_sum;
   logic             rsp_bad_range;
   logic             csr_wen = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   range_sum_book book = new();
   int unsigned   sent = 0;
   int unsigned   burst_left = 0;

   block_range_sum_point_update i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_first_pos (req_first_pos),
      .req_last_pos  (req_last_pos),
      .req_new_value (req_new_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_range_sum (rsp_range_sum),
      .rsp_bad_range (rsp_bad_range),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // watch both channels and the register port at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen)
            book.set_element_count(csr_wdata);
         if (start && !busy)
            book.apply_request(req_cmd, req_first_pos, req_last_pos, req_new_value);
         if (rsp_strobe)
            book.check_answer(rsp_range_sum, rsp_bad_range);
      end
   end

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // one beat; bursts of random length separated by random gaps
   task automatic send(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] f,
                       input logic [POS_W-1:0] l, input logic [VAL_W-1:0] v);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start         <= 1'b1;
      req_cmd       <= c;
      req_first_pos <= f;
      req_last_pos  <= l;
      req_new_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   // hold off until every sum has come back, then let any load or set finish
   task automatic drain_and_settle();
      start <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (QUIET) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] n);
      drain_and_settle();
      csr_wdata <= n;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic send_query();
      int unsigned lp, f, l, k, m, top;
      lp = book.loaded;
      case ((lp == 0) ? 0 : $urandom_range(0, 9))
         0: begin
            f = $urandom_range(0, 8191);
            l = $urandom_range(0, 8191);
         end
         1: begin   // start past end
            f = $urandom_range(2, lp + 2);
            l = $urandom_range(1, f - 1);
         end
         2: begin   // both ends in one block
            k   = $urandom_range(0, (lp - 1) / BLK);
            top = (k * BLK + BLK < lp) ? k * BLK + BLK : lp;
            f   = $urandom_range(k * BLK + 1, top);
            l   = $urandom_range(f, top);
         end
         3: begin   // block aligned, whole blocks only
            k = $urandom_range(0, (lp - 1) / BLK);
            m = $urandom_range(k, (lp - 1) / BLK);
            f = k * BLK + 1;
            l = (m * BLK + BLK < lp) ? m * BLK + BLK : lp;
         end
         4: begin
            f = 1;
            l = lp;
         end
         5: begin   // end beyond loaded values
            f = $urandom_range(1, lp + 1);
            l = lp + $urandom_range(1, 3);
         end
         default: begin
            f = $urandom_range(1, lp);
            l = $urandom_range(f, lp);
         end
      endcase
      send(brspu_pkg::CMD_QUERY, POS_W'(f), POS_W'(l), VAL_W'($urandom));
   endtask

   task automatic send_set();
      int unsigned lp, p;
      lp = book.loaded;
      p  = (lp == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(1, lp);
      send(brspu_pkg::CMD_SET, POS_W'(p), POS_W'($urandom), rand_value());
   endtask

   task automatic run_data_set(input logic [CNT_W-1:0] n);
      int unsigned lim, fill, ops, i;
      write_count(n);
      lim = (n > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : n;
      if (lim > 600)
         fill = $urandom_range(150, 400);
      else if ($urandom_range(0, 4) == 0)
         fill = $urandom_range(0, lim);
      else
         fill = lim + $urandom_range(0, 3);   // extra loads hit a full set
      for (i = 0; i < fill; i++)
         send(brspu_pkg::CMD_LOAD, POS_W'($urandom), POS_W'($urandom), rand_value());
      ops = $urandom_range(40, 90);
      for (i = 0; i < ops; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: send_query();
            12, 13, 14, 15: send_set();
            16, 17:  send(brspu_pkg::CMD_LOAD, POS_W'($urandom), POS_W'($urandom),
                          rand_value());
            18:      send(CMD_SPARE, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
            default: drain_and_settle();
         endcase
      end
   endtask

   initial begin
      logic [CNT_W-1:0] plan [9] = '{13'd64, 13'd1, 13'd65, 13'd0, 13'd4096,
                                     13'd129, 13'd5000, 13'd128, 13'd63};
      int unsigned      j;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty data set after reset: nothing loads, every query is bad
      send(brspu_pkg::CMD_QUERY, 13'd1, 13'd1, '0);
      send(brspu_pkg::CMD_LOAD, '0, '0, 16'h1234);
      send(brspu_pkg::CMD_SET, 13'd1, '0, 16'd5);
      send(CMD_SPARE, '1, '1, '1);

      // oversized count saturates to the full store
      write_count('1);
      send(brspu_pkg::CMD_LOAD, '1, '1, '1);
      send(brspu_pkg::CMD_LOAD, '0, '0, '0);
      send(brspu_pkg::CMD_LOAD, '1, '1, '1);
      send(brspu_pkg::CMD_QUERY, 13'd1, 13'd3, '0);
      send(brspu_pkg::CMD_QUERY, 13'd2, 13'd2, '1);
      send(brspu_pkg::CMD_QUERY, 13'd0, 13'd1, '0);
      send(brspu_pkg::CMD_QUERY, 13'd3, 13'd2, '0);
      send(brspu_pkg::CMD_QUERY, 13'd1, 13'd4, '0);
      send(brspu_pkg::CMD_QUERY, 13'd4096, 13'd4096, '0);
      send(brspu_pkg::CMD_QUERY, '1, '1, '0);
      send(brspu_pkg::CMD_SET, 13'd2, '0, '1);
      send(brspu_pkg::CMD_QUERY, 13'd1, 13'd3, '0);
      send(brspu_pkg::CMD_SET, 13'd0, '0, 16'd7);
      send(brspu_pkg::CMD_SET, 13'd4, '0, 16'd7);
      send(brspu_pkg::CMD_SET, '1, '1, 16'd7);
      send(brspu_pkg::CMD_QUERY, 13'd3, 13'd3, '0);

      j = 0;
      while (sent < ITEM_GOAL) begin
         run_data_set((j < 9) ? plan[j] : CNT_W'($urandom_range(1, 300)));
         j++;
      end

      drain_and_settle();
      if (book.errors == 0 && book.outstanding() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/brspu_pkg.sv
hw/rtl/brspu_ram.sv
hw/rtl/brspu_divider.sv
hw/rtl/block_range_sum_point_update.sv
verif/block_range_sum_point_update_tb.sv
